/* rtl/rea_pkg.sv */
// ----------------------------------------------------------------------------
// rea_pkg
// Shared types, widths, reset values and step table for the rotary encoder
// accelerator.
// ----------------------------------------------------------------------------
package rea_pkg;

  localparam int unsigned HistoryDepthDef = 4;

  localparam int unsigned PosW     = 8;
  localparam int unsigned TickW    = 16;
  localparam int unsigned IntvW    = 13;
  localparam int unsigned StepW    = 8;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PosW-1:0]  PosMinRst    = 8'd1;
  localparam logic [PosW-1:0]  PosMaxRst    = 8'd15;
  localparam logic [TickW-1:0] IdleRst      = 16'd50000;
  localparam logic [IntvW-1:0] CapRst       = 13'd5000;
  localparam logic [IntvW-1:0] FastThrRst   = 13'd200;
  localparam logic [IntvW-1:0] MediumThrRst = 13'd400;
  localparam logic [IntvW-1:0] SlowThrRst   = 13'd1000;
  localparam logic [IntvW-1:0] HistRst      = 13'd1000;
  localparam logic [PosW-1:0]  PosRst       = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POS_MIN    = 3'd0,
    CFG_POS_MAX    = 3'd1,
    CFG_IDLE       = 3'd2,
    CFG_CAP        = 3'd3,
    CFG_FAST_THR   = 3'd4,
    CFG_MEDIUM_THR = 3'd5,
    CFG_SLOW_THR   = 3'd6
  } cfg_reg_e;

  typedef logic [1:0] phase_t;
  localparam phase_t PhaseIdle = 2'b00;
  localparam phase_t PhaseUp   = 2'b01;
  localparam phase_t PhaseDown = 2'b10;

  typedef logic [LevelW-1:0] level_t;
  localparam level_t LevelSlow    = 2'd0;
  localparam level_t LevelMedium  = 2'd1;
  localparam level_t LevelFast    = 2'd2;
  localparam level_t LevelFastest = 2'd3;

  typedef struct packed {
    logic [PosW-1:0]  pos_min;
    logic [PosW-1:0]  pos_max;
    logic [TickW-1:0] idle_timeout;
    logic [IntvW-1:0] interval_cap;
    logic [IntvW-1:0] fast_thr;
    logic [IntvW-1:0] medium_thr;
    logic [IntvW-1:0] slow_thr;
  } cfg_t;

  typedef struct packed {
    logic signed [StepW-1:0] step;
    logic                    moved;
    logic [PosW-1:0]         position;
    level_t                  speed_level;
  } result_t;

  // Signed step for a detent, by direction and speed level.
  function automatic logic signed [StepW-1:0] step_lookup(input logic up, input level_t lvl);
    logic signed [StepW-1:0] s;
    case (lvl)
      LevelSlow:    s = up ? 8'sd1   : -8'sd1;
      LevelMedium:  s = up ? 8'sd5   : -8'sd4;
      LevelFast:    s = up ? 8'sd20  : -8'sd10;
      LevelFastest: s = up ? 8'sd100 : -8'sd50;
      default:      s = '0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/rea_if.sv */
// ----------------------------------------------------------------------------
// rea_if
// Valid/ready channels of the rotary encoder accelerator: pin samples in,
// step results out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface rea_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;

  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input pin_a, input pin_b, output ready);
endinterface

interface rea_out_if import rea_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [StepW-1:0] step;
  logic                    moved;
  logic [PosW-1:0]         position;
  logic [LevelW-1:0]       speed_level;

  modport source (output valid, output step, output moved, output position,
                  output speed_level, input ready);
  modport sink   (input valid, input step, input moved, input position,
                  input speed_level, output ready);
endinterface

interface rea_cfg_if import rea_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rea_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rea_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rea_cfg_regs import rea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_idx_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_reg_e'(wr_idx_i))
        CFG_POS_MIN:    cfg_d.pos_min      = wr_data_i[PosW-1:0];
        CFG_POS_MAX:    cfg_d.pos_max      = wr_data_i[PosW-1:0];
        CFG_IDLE:       cfg_d.idle_timeout = wr_data_i[TickW-1:0];
        CFG_CAP:        cfg_d.interval_cap = wr_data_i[IntvW-1:0];
        CFG_FAST_THR:   cfg_d.fast_thr     = wr_data_i[IntvW-1:0];
        CFG_MEDIUM_THR: cfg_d.medium_thr   = wr_data_i[IntvW-1:0];
        CFG_SLOW_THR:   cfg_d.slow_thr     = wr_data_i[IntvW-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min      <= PosMinRst;
      cfg_q.pos_max      <= PosMaxRst;
      cfg_q.idle_timeout <= IdleRst;
      cfg_q.interval_cap <= CapRst;
      cfg_q.fast_thr     <= FastThrRst;
      cfg_q.medium_thr   <= MediumThrRst;
      cfg_q.slow_thr     <= SlowThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/rea_tracker.sv */
// ----------------------------------------------------------------------------
// rea_tracker
// Per-tick encoder state: tick counter, interval ring with running sum,
// speed level and saturating position. Result is formed in the accept cycle.
// ----------------------------------------------------------------------------
module rea_tracker import rea_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  logic    pin_a_i,
  input  logic    pin_b_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int unsigned SlotW = $clog2(HISTORY_DEPTH);
  // Sum of HISTORY_DEPTH intervals, each below 2**IntvW.
  localparam int unsigned SumW  = IntvW + $clog2(HISTORY_DEPTH);
  localparam logic [SumW-1:0] DepthS  = SumW'(HISTORY_DEPTH);
  localparam logic [SumW-1:0] SumRst  = SumW'(HistRst) * DepthS;

  logic [TickW-1:0] tick_q, tick_d;
  phase_t           last_q;
  logic [IntvW-1:0] hist_q [HISTORY_DEPTH];
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SumW-1:0]  sum_q, sum_d;
  level_t           level_q, level_d;
  logic [PosW-1:0]  pos_q, pos_d;

  phase_t           phase;
  logic [TickW-1:0] tick_inc, tick_mid;
  logic             timeout, record, step_up, step_dn;
  logic [IntvW-1:0] interval, old_entry;
  logic [SumW-1:0]  cap_sum, base_sum, sum_new;
  level_t           level_new;

  always_comb begin
    phase    = {pin_b_i, pin_a_i};
    tick_inc = tick_q + 1'b1;
    timeout  = (tick_inc == cfg_i.idle_timeout);
    tick_mid = timeout ? '0 : tick_inc;
    record   = (phase != last_q) && (last_q == PhaseIdle);
    interval = (tick_mid > TickW'(cfg_i.interval_cap)) ? cfg_i.interval_cap
                                                       : tick_mid[IntvW-1:0];

    // On timeout every entry reads as the cap, so the sum is cap * depth.
    cap_sum   = SumW'(cfg_i.interval_cap) * DepthS;
    old_entry = timeout ? cfg_i.interval_cap : hist_q[slot_q];
    base_sum  = timeout ? cap_sum : sum_q;
    sum_new   = base_sum - SumW'(old_entry) + SumW'(interval);

    // floor(sum / D) < T  is the same test as  sum < T * D
    if (sum_new < SumW'(cfg_i.fast_thr) * DepthS) begin
      level_new = LevelFastest;
    end else if (sum_new < SumW'(cfg_i.medium_thr) * DepthS) begin
      level_new = LevelFast;
    end else if (sum_new < SumW'(cfg_i.slow_thr) * DepthS) begin
      level_new = LevelMedium;
    end else begin
      level_new = LevelSlow;
    end

    step_up = record && (phase == PhaseUp);
    step_dn = record && (phase == PhaseDown);

    tick_d = record ? '0 : tick_mid;
    slot_d = slot_q;
    if (record) begin
      slot_d = (slot_q == SlotW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
    sum_d = record ? sum_new : (timeout ? cap_sum : sum_q);

    if (record) begin
      level_d = level_new;
    end else if (timeout) begin
      level_d = LevelSlow;
    end else begin
      level_d = level_q;
    end

    pos_d = pos_q;
    if (step_up && (pos_q < cfg_i.pos_max)) begin
      pos_d = pos_q + 1'b1;
    end else if (step_dn && (pos_q > cfg_i.pos_min)) begin
      pos_d = pos_q - 1'b1;
    end

    result_o.step        = (step_up || step_dn) ? step_lookup(step_up, level_new) : '0;
    result_o.moved       = step_up || step_dn;
    result_o.position    = pos_d;
    result_o.speed_level = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      last_q  <= PhaseIdle;
      slot_q  <= '0;
      sum_q   <= SumRst;
      level_q <= LevelSlow;
      pos_q   <= PosRst;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist_q[k] <= HistRst;
      end
    end else if (accept_i) begin
      tick_q  <= tick_d;
      last_q  <= phase;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
      level_q <= level_d;
      pos_q   <= pos_d;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        if (record && (slot_q == SlotW'(k))) begin
          hist_q[k] <= interval;
        end else if (timeout) begin
          hist_q[k] <= cfg_i.interval_cap;
        end
      end
    end
  end

endmodule

/* rtl/rea_out_stage.sv */
// ----------------------------------------------------------------------------
// rea_out_stage
// Result register between the tracker and the output channel.
// ----------------------------------------------------------------------------
module rea_out_stage import rea_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t result_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // Take a new request whenever the register is empty or being drained.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

/* rtl/rotary_encoder_accelerator_top.sv */
// ----------------------------------------------------------------------------
// rotary_encoder_accelerator_top
// Rotary encoder decoder with speed-dependent step size.
// ----------------------------------------------------------------------------
// Each input request is one tick's sample of the encoder pins (pin_a is phase
// bit 0, pin_b bit 1); each accepted request yields exactly one result with
// the signed step, a moved flag, the saturating position and the speed level.
// Throughput is one request per clock. All per-tick work (counter, interval
// ring update, running sum, threshold compares, position update) is done in
// the cycle the request is accepted, and the result shows up in the output
// register on the next cycle. in_i.ready drops only while that register holds
// a result the consumer has not taken. The interval ring keeps a running sum,
// so the average test is a compare of the sum against threshold * depth. All
// state is ready right after reset; there is no init sweep. Configuration
// writes are always taken (cfg_i.ready is tied high) and are meant to happen
// while the block is idle; unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module rotary_encoder_accelerator_top import rea_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rea_in_if.sink     in_i,
  rea_out_if.source  out_o,
  rea_cfg_if.sink    cfg_i
);

  cfg_t    cfg;
  result_t next_result;
  result_t out_result;
  logic    in_ready;
  logic    accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  rea_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  rea_tracker #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pin_a_i  (in_i.pin_a),
    .pin_b_i  (in_i.pin_b),
    .cfg_i    (cfg),
    .result_o (next_result)
  );

  rea_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .result_i    (next_result),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_result)
  );

  // Fan the result register out onto the channel fields.
  assign out_o.step        = out_result.step;
  assign out_o.moved       = out_result.moved;
  assign out_o.position    = out_result.position;
  assign out_o.speed_level = out_result.speed_level;

endmodule

/* rtl/rea_checker.sv */
// ----------------------------------------------------------------------------
// rea_checker
// Port-level assertions for the rotary encoder accelerator, bound to the top.
// ----------------------------------------------------------------------------
module rea_checker import rea_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [StepW-1:0] step_i,
  input logic                    moved_i,
  input logic [PosW-1:0]         position_i,
  input logic [LevelW-1:0]       speed_level_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(step_i) && $stable(moved_i)
      && $stable(position_i) && $stable(speed_level_i))
    else $error("result changed while stalled");

  // Every accepted request produces a result on the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request without a result");

  // An empty output register never back-pressures the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // The step is nonzero exactly when moved is set.
  a_moved_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (moved_i == (step_i != '0)))
    else $error("moved flag and step disagree");

  // At the slow level a step is a single detent.
  a_slow_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && moved_i && (speed_level_i == LevelSlow)
      |-> (step_i == 8'sd1) || (step_i == -8'sd1))
    else $error("slow level step is not one");

endmodule

bind rotary_encoder_accelerator_top rea_checker u_rea_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .step_i        (out_o.step),
  .moved_i       (out_o.moved),
  .position_i    (out_o.position),
  .speed_level_i (out_o.speed_level)
);
